// ===== hw/rtl/pfti_pkg.sv =====
// ----------------------------------------------------------------------------
// pfti_pkg
// Shared constants, types and register codes of the floor tile indexer.
// ----------------------------------------------------------------------------
package pfti_pkg;

  // Screen and texture geometry
  localparam int unsigned SCREEN_WIDTH  = 640;
  localparam int unsigned SCREEN_HEIGHT = 400;
  localparam int unsigned TILE_LOG2     = 3;   // texture is 2**TILE_LOG2 square

  // Field widths
  localparam int unsigned X_W   = 10;
  localparam int unsigned Y_W   = 9;
  localparam int unsigned IDX_W = 7;

  // Palette layout
  localparam logic [IDX_W-1:0] SKY_INDEX = 7'd19;
  localparam logic [IDX_W-1:0] TILE_BASE = 7'd20;

  // Flat tiling cell shifts and perspective row shift
  localparam int unsigned FINE_SHIFT   = 2;
  localparam int unsigned COARSE_SHIFT = 3;
  localparam int unsigned ROW_SHIFT    = 2;

  // Horizon clamp limits and reset value
  localparam logic [Y_W-1:0] HORIZON_MIN   = Y_W'(1);
  localparam logic [Y_W-1:0] HORIZON_MAX   = Y_W'(SCREEN_HEIGHT - 1);
  localparam logic [Y_W-1:0] HORIZON_RESET = Y_W'(133);

  // Depth: z = (SCREEN_HEIGHT << DEPTH_SHIFT) / (y - horizon)
  localparam int unsigned DEPTH_SHIFT = 9;
  localparam int unsigned COL_SHIFT   = DEPTH_SHIFT + 4;
  localparam int unsigned DEPTH_NUM   = SCREEN_HEIGHT << DEPTH_SHIFT;
  localparam int unsigned QW          = $clog2(DEPTH_NUM + 1);

  // Pipelined divider: quotient bits retired per stage
  localparam int unsigned DIV_RADIX  = 3;
  localparam int unsigned DIV_STAGES = (QW + DIV_RADIX - 1) / DIV_RADIX;
  localparam int unsigned QPW        = DIV_STAGES * DIV_RADIX;
  localparam logic [QPW-1:0] DEPTH_NUM_P = QPW'(DEPTH_NUM);

  // Column offset x - SCREEN_WIDTH/2 and its product with z
  localparam int unsigned HALF_W = SCREEN_WIDTH / 2;
  localparam int unsigned DXW    = 11;
  localparam int unsigned PROD_W = DXW + QW + 1;

  // Index adder width
  localparam int unsigned SUM_W = IDX_W + 2 * TILE_LOG2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERSP   = 2'd0,
    CFG_COARSE  = 2'd1,
    CFG_HORIZON = 2'd2
  } pfti_cfg_idx_e;

  // Live configuration
  typedef struct packed {
    logic           persp;
    logic           coarse;
    logic [Y_W-1:0] hrow;
  } pfti_cfg_t;

  // Per-pixel sideband carried along the pipeline
  typedef struct packed {
    logic                 sky;
    logic                 use_prod;  // column texel comes from the product
    logic [TILE_LOG2-1:0] u;
    logic [TILE_LOG2-1:0] v;
    logic signed [DXW-1:0] dx;
  } pfti_side_t;

endpackage

// ===== hw/rtl/pfti_pixel_if.sv =====
// ----------------------------------------------------------------------------
// pfti_pixel_if
// Pixel coordinate channel: valid/ready with screen column and row.
// ----------------------------------------------------------------------------
interface pfti_pixel_if;
  import pfti_pkg::*;

  logic           valid;
  logic           ready;
  logic [X_W-1:0] pixel_x;
  logic [Y_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);

endinterface

// ===== hw/rtl/pfti_index_if.sv =====
// ----------------------------------------------------------------------------
// pfti_index_if
// Palette index channel: valid/ready with index and sky flag.
// ----------------------------------------------------------------------------
interface pfti_index_if;
  import pfti_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] palette_index;
  logic             is_sky;

  modport source (output valid, output palette_index, output is_sky, input ready);
  modport sink   (input valid, input palette_index, input is_sky, output ready);

endinterface

// ===== hw/rtl/pfti_setup.sv =====
// ----------------------------------------------------------------------------
// pfti_setup
// First stage: horizon clamp, sky test, flat or row texels, divisor and x offset.
// ----------------------------------------------------------------------------
module pfti_setup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  pfti_pixel_if.sink           pixel_i,
  input  pfti_pkg::pfti_cfg_t  cfg_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pfti_pkg::pfti_side_t out_side_o,
  output logic [pfti_pkg::Y_W-1:0] out_divisor_o
);
  import pfti_pkg::*;

  logic           valid_q;
  logic           rdy;
  logic [Y_W-1:0] horizon;
  logic           sky;
  pfti_side_t     side_d, side_q;
  logic [Y_W-1:0] divisor_d, divisor_q;

  assign rdy           = !valid_q || out_ready_i;
  assign pixel_i.ready = rdy;

  // Clamp horizon into 1..height-1
  always_comb begin
    if (cfg_i.hrow < HORIZON_MIN) begin
      horizon = HORIZON_MIN;
    end else if (cfg_i.hrow > HORIZON_MAX) begin
      horizon = HORIZON_MAX;
    end else begin
      horizon = cfg_i.hrow;
    end
  end

  assign sky = cfg_i.persp && (pixel_i.pixel_y <= horizon);

  // Sideband: flat texels or perspective row texel, and column offset
  always_comb begin
    side_d.sky      = sky;
    side_d.use_prod = cfg_i.persp && !sky;
    if (cfg_i.persp) begin
      side_d.u = '0;
      side_d.v = TILE_LOG2'(pixel_i.pixel_y >> ROW_SHIFT);
    end else if (cfg_i.coarse) begin
      side_d.u = TILE_LOG2'(pixel_i.pixel_x >> COARSE_SHIFT);
      side_d.v = TILE_LOG2'(pixel_i.pixel_y >> COARSE_SHIFT);
    end else begin
      side_d.u = TILE_LOG2'(pixel_i.pixel_x >> FINE_SHIFT);
      side_d.v = TILE_LOG2'(pixel_i.pixel_y >> FINE_SHIFT);
    end
    side_d.dx = $signed(DXW'(pixel_i.pixel_x) - DXW'(HALF_W));
  end

  // Wraps or is zero on sky pixels; the quotient is then unused
  assign divisor_d = pixel_i.pixel_y - horizon;

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rdy) begin
      valid_q <= pixel_i.valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (rdy && pixel_i.valid) begin
      side_q    <= side_d;
      divisor_q <= divisor_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_side_o    = side_q;
  assign out_divisor_o = divisor_q;

endmodule

// ===== hw/rtl/pfti_divider.sv =====
// ----------------------------------------------------------------------------
// pfti_divider
// Pipelined restoring divider: constant depth numerator over the row
// distance, DIV_RADIX quotient bits per register stage.
// ----------------------------------------------------------------------------
module pfti_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  pfti_pkg::pfti_side_t     in_side_i,
  input  logic [pfti_pkg::Y_W-1:0] in_divisor_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pfti_pkg::pfti_side_t     out_side_o,
  output logic [pfti_pkg::QW-1:0]  out_quot_o
);
  import pfti_pkg::*;

  localparam int unsigned LAST = DIV_STAGES - 1;

  logic           valid_q [DIV_STAGES];
  logic           rdy     [DIV_STAGES+1];
  logic [Y_W-1:0] dvs_q   [DIV_STAGES];
  logic [Y_W-1:0] rem_q   [DIV_STAGES];
  logic [QPW-1:0] quo_q   [DIV_STAGES];
  pfti_side_t     side_q  [DIV_STAGES];

  assign rdy[DIV_STAGES] = out_ready_i;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    localparam logic [DIV_RADIX-1:0] NUM_BITS =
      DEPTH_NUM_P[QPW-1-DIV_RADIX*s -: DIV_RADIX];

    logic           valid_in;
    logic [Y_W-1:0] dvs_in, rem_in, rem_d;
    logic [QPW-1:0] quo_in, quo_d;
    pfti_side_t     side_in;
    logic [Y_W:0]   trial;
    logic [DIV_RADIX-1:0] nbits;

    // Stage inputs
    if (s == 0) begin : g_first
      assign valid_in = in_valid_i;
      assign dvs_in   = in_divisor_i;
      assign rem_in   = '0;
      assign quo_in   = '0;
      assign side_in  = in_side_i;
    end else begin : g_next
      assign valid_in = valid_q[s-1];
      assign dvs_in   = dvs_q[s-1];
      assign rem_in   = rem_q[s-1];
      assign quo_in   = quo_q[s-1];
      assign side_in  = side_q[s-1];
    end

    assign rdy[s] = !valid_q[s] || rdy[s+1];

    // Shift-compare-subtract over this stage's numerator bits
    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      nbits = NUM_BITS;
      trial = '0;
      for (int j = 0; j < DIV_RADIX; j++) begin
        trial = {rem_d, nbits[DIV_RADIX-1]};
        nbits = nbits << 1;
        if (trial >= {1'b0, dvs_in}) begin
          trial = trial - {1'b0, dvs_in};
          quo_d = {quo_d[QPW-2:0], 1'b1};
        end else begin
          quo_d = {quo_d[QPW-2:0], 1'b0};
        end
        rem_d = trial[Y_W-1:0];
      end
    end

    // Stage valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_q[s] <= valid_in;
      end
    end

    // Stage payload
    always_ff @(posedge clk_i) begin
      if (rdy[s] && valid_in) begin
        dvs_q[s]  <= dvs_in;
        rem_q[s]  <= rem_d;
        quo_q[s]  <= quo_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = valid_q[LAST];
  assign out_side_o  = side_q[LAST];
  assign out_quot_o  = quo_q[LAST][QW-1:0];

  // Final remainder must lie below a nonzero divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAST] && (dvs_q[LAST] != '0) |-> rem_q[LAST] < dvs_q[LAST])
    else $error("pfti_divider: remainder not below divisor");

  // A stalled quotient stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LAST] && !out_ready_i |=> valid_q[LAST] && $stable(quo_q[LAST]))
    else $error("pfti_divider: stalled quotient changed");

endmodule

// ===== hw/rtl/pfti_column.sv =====
// ----------------------------------------------------------------------------
// pfti_column
// Column texel multiply stage and palette index output register.
// ----------------------------------------------------------------------------
module pfti_column (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pfti_pkg::pfti_side_t    in_side_i,
  input  logic [pfti_pkg::QW-1:0] in_quot_i,
  pfti_index_if.source            index_o
);
  import pfti_pkg::*;

  logic                     mul_valid_q;
  logic                     mul_rdy;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  pfti_side_t               mul_side_q;

  logic                     out_valid_q;
  logic                     out_rdy;
  logic [TILE_LOG2-1:0]     u;
  logic [SUM_W-1:0]         idx_wide;
  logic [IDX_W-1:0]         idx_d, idx_q;
  logic                     sky_q;

  assign out_rdy    = !out_valid_q || index_o.ready;
  assign mul_rdy    = !mul_valid_q || out_rdy;
  assign in_ready_o = mul_rdy;

  // (x - width/2) * z, two's complement
  assign prod_d = in_side_i.dx * $signed({1'b0, in_quot_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (mul_rdy) begin
      mul_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_rdy && in_valid_i) begin
      prod_q     <= prod_d;
      mul_side_q <= in_side_i;
    end
  end

  // Texel select and palette offset
  assign u        = mul_side_q.use_prod ? prod_q[COL_SHIFT +: TILE_LOG2] : mul_side_q.u;
  assign idx_wide = SUM_W'(TILE_BASE) + SUM_W'({mul_side_q.v, u});
  assign idx_d    = mul_side_q.sky ? SKY_INDEX : idx_wide[IDX_W-1:0];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_rdy) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && mul_valid_q) begin
      idx_q <= idx_d;
      sky_q <= mul_side_q.sky;
    end
  end

  assign index_o.valid         = out_valid_q;
  assign index_o.palette_index = idx_q;
  assign index_o.is_sky        = sky_q;

endmodule

// ===== hw/rtl/perspective_floor_tile_indexer.sv =====
// ----------------------------------------------------------------------------
// perspective_floor_tile_indexer
// Maps a screen pixel to its palette index, flat tiled or perspective floor.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pixel_i   in   valid/ready    pixel_x[9:0], pixel_y[8:0]
//  index_o   out  valid/ready    palette_index[6:0], is_sky
//  cfg       in   cfg_we_i       cfg_idx_i[1:0], cfg_wdata_i[8:0]
//
//  One pixel per cycle sustained unless the output stalls; stages in order:
//  setup stage, DIV_STAGES divider stages at 3 quotient bits each, multiply
//  stage, output register. Each stage has its own valid and takes new data
//  when empty or when the next stage moves, so bubbles close up under stall.
//  Reset clears all valids and loads the register reset values.
// ----------------------------------------------------------------------------
module perspective_floor_tile_indexer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  pfti_pixel_if.sink                      pixel_i,
  pfti_index_if.source                    index_o,
  input  logic                            cfg_we_i,
  input  logic [pfti_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfti_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import pfti_pkg::*;

  pfti_cfg_t      cfg_d, cfg_q;

  logic           setup_valid, setup_ready;
  pfti_side_t     setup_side;
  logic [Y_W-1:0] setup_divisor;

  logic           div_valid, div_ready;
  pfti_side_t     div_side;
  logic [QW-1:0]  div_quot;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pfti_cfg_idx_e'(cfg_idx_i))
        CFG_PERSP:   cfg_d.persp  = cfg_wdata_i[0];
        CFG_COARSE:  cfg_d.coarse = cfg_wdata_i[0];
        CFG_HORIZON: cfg_d.hrow   = cfg_wdata_i[Y_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.persp  <= 1'b0;
      cfg_q.coarse <= 1'b0;
      cfg_q.hrow   <= HORIZON_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline
  pfti_setup u_setup (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pixel_i       (pixel_i),
    .cfg_i         (cfg_q),
    .out_valid_o   (setup_valid),
    .out_ready_i   (setup_ready),
    .out_side_o    (setup_side),
    .out_divisor_o (setup_divisor)
  );

  pfti_divider u_divider (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (setup_valid),
    .in_ready_o   (setup_ready),
    .in_side_i    (setup_side),
    .in_divisor_i (setup_divisor),
    .out_valid_o  (div_valid),
    .out_ready_i  (div_ready),
    .out_side_o   (div_side),
    .out_quot_o   (div_quot)
  );

  pfti_column u_column (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (div_valid),
    .in_ready_o (div_ready),
    .in_side_i  (div_side),
    .in_quot_i  (div_quot),
    .index_o    (index_o)
  );

  // Sky results always carry the sky palette entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_o.valid && index_o.is_sky |-> index_o.palette_index == SKY_INDEX)
    else $error("perspective_floor_tile_indexer: sky result with tile index");

  // Flat tiling never yields sky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    index_o.valid && !cfg_q.persp |-> !index_o.is_sky)
    else $error("perspective_floor_tile_indexer: sky in flat mode");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the perspective floor tile indexer. Pixels go in
// through the coordinate channel and every accepted pixel gets a predicted
// palette index. Each index transfer is checked in order against that
// prediction. The run covers flat and perspective modes, horizon clamping,
// random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import pfti_pkg::*;

  localparam int unsigned PIPE_LATENCY = 3 + DIV_STAGES;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned MAX_GAP      = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register slot

  typedef struct {
    logic [IDX_W-1:0] palette_index;
    logic             is_sky;
  } index_item_t;

  // Tracks register state, predicts the index of each accepted pixel and
  // checks output transfers in order.
  class index_ledger;
    logic           persp;
    logic           coarse;
    logic [Y_W-1:0] hrow;
    index_item_t    expected_indices[$];
    int unsigned    mismatch_count;
    int unsigned    pixels_noted;
    int unsigned    indices_checked;

    function new();
      persp           = 1'b0;
      coarse          = 1'b0;
      hrow            = HORIZON_RESET;
      mismatch_count  = 0;
      pixels_noted    = 0;
      indices_checked = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PERSP:   persp  = data[0];
        CFG_COARSE:  coarse = data[0];
        CFG_HORIZON: hrow   = data[Y_W-1:0];
        default: ;  // unmapped index, no effect
      endcase
    endfunction

    function index_item_t predict_index(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      index_item_t          r;
      int unsigned          h;
      int unsigned          shift;
      int unsigned          depth;
      longint               dx;
      longint               prod;
      logic [TILE_LOG2-1:0] u;
      logic [TILE_LOG2-1:0] v;
      r.is_sky = 1'b0;
      if (persp) begin
        h = hrow;
        if (h < HORIZON_MIN) h = HORIZON_MIN;
        if (h > HORIZON_MAX) h = HORIZON_MAX;
        // horizon row and everything above it is sky
        if (y <= h) begin
          r.palette_index = SKY_INDEX;
          r.is_sky        = 1'b1;
          return r;
        end
        depth = (SCREEN_HEIGHT << DEPTH_SHIFT) / (int'(y) - h);
        dx    = longint'(x) - longint'(SCREEN_WIDTH / 2);
        prod  = (dx * longint'(depth)) >>> COL_SHIFT;
        u     = prod[TILE_LOG2-1:0];
        v     = TILE_LOG2'(y >> ROW_SHIFT);
      end else begin
        shift = coarse ? COARSE_SHIFT : FINE_SHIFT;
        u     = TILE_LOG2'(x >> shift);
        v     = TILE_LOG2'(y >> shift);
      end
      r.palette_index = IDX_W'(int'(TILE_BASE) + int'(u) + int'(v) * (1 << TILE_LOG2));
      return r;
    endfunction

    function void note_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      expected_indices.push_back(predict_index(x, y));
      pixels_noted++;
    endfunction

    function void check_index(logic [IDX_W-1:0] idx, logic sky);
      index_item_t exp_item;
      if (expected_indices.size() == 0) begin
        $display("%0t: unexpected index transfer: index %0d sky %0b", $time, idx, sky);
        mismatch_count++;
        return;
      end
      exp_item = expected_indices.pop_front();
      indices_checked++;
      if (idx !== exp_item.palette_index) begin
        $display("%0t: palette_index mismatch: expected %0d, actual %0d",
                 $time, exp_item.palette_index, idx);
        mismatch_count++;
      end
      if (sky !== exp_item.is_sky) begin
        $display("%0t: is_sky mismatch: expected %0b, actual %0b",
                 $time, exp_item.is_sky, sky);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_indices.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  pfti_pixel_if pix ();
  pfti_index_if idx ();

  index_ledger ledger = new();

  // Idling controls, written by the stimulus process only
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_seq     = 0;
  int unsigned cur_horizon  = HORIZON_RESET;

  perspective_floor_tile_indexer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pixel_i     (pix),
    .index_o     (idx),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offer one pixel, wait for its transfer, then maybe go idle
  task automatic send_pixel(input logic [X_W-1:0] x, input logic [Y_W-1:0] y);
    int unsigned gap;
    gap = 0;
    pix.valid   <= 1'b1;
    pix.pixel_x <= x;
    pix.pixel_y <= y;
    do @(posedge clk_i); while (!pix.ready);
    ledger.note_pixel(x, y);
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop offering and wait until every predicted index has come back
  task automatic drain_indices();
    pix.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write, then the enable is dropped before the ledger is updated
  task automatic write_reg(input logic [CFG_IDX_W-1:0] ridx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= ridx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    ledger.set_reg(ridx, data);
    if (ridx == CFG_HORIZON) cur_horizon = data;
  endtask

  // Random pixels, biased toward the horizon band
  task automatic run_pixels(input int unsigned count);
    int unsigned x;
    int          y;
    int          h;
    for (int unsigned i = 0; i < count; i++) begin
      h = cur_horizon;
      if (h < 1) h = 1;
      if (h > SCREEN_HEIGHT - 1) h = SCREEN_HEIGHT - 1;
      x = ($urandom_range(7) == 0) ? $urandom_range(1023) : $urandom_range(SCREEN_WIDTH - 1);
      case ($urandom_range(7))
        0, 1: begin
          y = h + int'($urandom_range(6)) - 3;
          if (y < 0) y = 0;
          if (y > 511) y = 511;
        end
        2:       y = $urandom_range(511);
        default: y = $urandom_range(SCREEN_HEIGHT - 1);
      endcase
      send_pixel(X_W'(x), Y_W'(y));
    end
  endtask

  task automatic random_setting();
    int unsigned hsel;
    int unsigned hval;
    hsel = $urandom_range(7);
    case (hsel)
      0:       hval = 0;
      1:       hval = 1;
      2:       hval = SCREEN_HEIGHT - 1;
      3:       hval = 511;
      4:       hval = SCREEN_HEIGHT;
      default: hval = $urandom_range(511);
    endcase
    write_reg(CFG_PERSP, CFG_DATA_W'($urandom_range(1)));
    write_reg(CFG_COARSE, CFG_DATA_W'($urandom_range(1)));
    write_reg(CFG_HORIZON, CFG_DATA_W'(hval));
  endtask

  // Output side: check transfers, stall at random, long hold on request
  initial begin
    int unsigned seen_seq;
    int unsigned hold_left;
    seen_seq  = 0;
    hold_left = 0;
    idx.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && idx.valid && idx.ready) ledger.check_index(idx.palette_index, idx.is_sky);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        idx.ready <= 1'b0;
      end else begin
        idx.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: cycles without any transfer on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (pix.valid && pix.ready) || (idx.valid && idx.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    int unsigned errors;
    pix.valid   <= 1'b0;
    pix.pixel_x <= '0;
    pix.pixel_y <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= CFG_PERSP;
    cfg_wdata_i <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // flat tiling, fine cells (reset settings)
    send_pixel(0, 0);
    send_pixel(1023, 511);
    send_pixel(13, 29);
    send_pixel(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 1));
    drain_indices();
    // flat tiling, coarse cells
    write_reg(CFG_COARSE, 1);
    send_pixel(0, 0);
    send_pixel(1023, 511);
    send_pixel(100, 200);
    drain_indices();
    // perspective, reset horizon: on, above and just below the horizon
    write_reg(CFG_PERSP, 1);
    send_pixel(320, 133);
    send_pixel(5, 0);
    send_pixel(0, 134);
    send_pixel(1023, 134);
    send_pixel(319, 135);
    send_pixel(320, 300);
    send_pixel(X_W'(SCREEN_WIDTH - 1), Y_W'(SCREEN_HEIGHT - 1));
    send_pixel(1023, 511);
    drain_indices();
    // horizon below range, clamped up to row one
    write_reg(CFG_HORIZON, 0);
    send_pixel(7, 0);
    send_pixel(7, 1);
    send_pixel(7, 2);
    drain_indices();
    // horizon above range, clamped to the last screen row; rows off screen
    write_reg(CFG_HORIZON, 511);
    send_pixel(500, Y_W'(SCREEN_HEIGHT - 1));
    send_pixel(500, Y_W'(SCREEN_HEIGHT));
    send_pixel(0, 511);
    drain_indices();
    // write to the unmapped slot must change nothing
    write_reg(CFG_SPARE, 9'h1FF);
    send_pixel(200, 450);
    drain_indices();

    // random settings under each idling mode
    for (int unsigned mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      for (int unsigned s = 0; s < 4; s++) begin
        drain_indices();
        random_setting();
        run_pixels(40);
      end
    end

    // back-pressure: output held off while pixels keep coming
    drain_indices();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(CFG_PERSP, 1);
    write_reg(CFG_HORIZON, 150);
    hold_seq++;
    run_pixels(60);
    drain_indices();

    repeat (PIPE_LATENCY + 10) @(posedge clk_i);
    errors = ledger.mismatch_count + ledger.pending();
    $display("summary: %0d pixels sent, %0d indices checked, %0d errors",
             ledger.pixels_noted, ledger.indices_checked, errors);
    $display("summary: flat and perspective modes, clamped horizons, four idling modes, hold-off");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
